// File: hdl/assert_macros.svh
// assertion helpers used by the checker file
// same-cycle and next-cycle implication, both gated by the active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/stbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbl_pkg
// shared types and codes of the sorted table engine
// ----------------------------------------------------------------------------
package stbl_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int DATA_W           = 32;
  localparam int OCC_W            = 5;

  // request opcodes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_DUMP   = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_FIND,
    S_DEL,
    S_DUMP
  } state_t;

  typedef struct packed {
    status_t                   status;
    logic                      found;
    logic signed [DATA_W-1:0]  entry;
    logic                      last;
  } result_t;

endpackage

// File: hdl/sorted_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_engine
// bounded table of signed 32-bit values kept in ascending order
// ----------------------------------------------------------------------------
// A request (in_func, in_value) is taken at a rising edge where start is high
// and busy is low. Results come out on the out_ ports with out_valid high for
// exactly one cycle each; the receiver cannot stall them, so it must take
// every cycle that out_valid is high. out_last marks the final result of a
// request. Insert, delete and search give one result; a dump gives one result
// per held entry in ascending order, on consecutive cycles. Requests that fail
// at once (insert into a full table, any operation on an empty table other
// than insert) give their result on the next cycle and leave busy low. An
// insert walks down from the top, moving each entry equal to or above its
// value up one slot; a search scans up from the lowest entry to a match or
// the end; a delete scans the same way, then shifts each entry above the
// match down one slot; a dump reads the entries upward. These steps follow
// from the entry memory, which reads one entry and writes one entry per
// cycle through a registered read port. The table needs no clearing pass
// after reset: only entries below the count are ever used.
// ----------------------------------------------------------------------------
module sorted_table_engine #(
  parameter int CAPACITY = stbl_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request side
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_func,
  input  logic signed [stbl_pkg::DATA_W-1:0] in_value,
  // result side, each result valid for a single cycle, no back pressure
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic                               out_found,
  output logic signed [stbl_pkg::DATA_W-1:0] out_entry,
  output logic [stbl_pkg::OCC_W-1:0]         out_occupancy,
  output logic                               out_last
);

  // address width of the entry memory and width of the fill count
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // memory port wires
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [stbl_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [stbl_pkg::DATA_W-1:0] mem_rdata;

  // registered result from the sequencer
  logic                        res_valid;
  stbl_pkg::result_t           res;
  logic [CW-1:0]               res_occ;
  // occupancy is reported modulo 32, zero extended for small tables
  logic [CW+stbl_pkg::OCC_W-1:0] occ_ext;

  // sequencer: scan, shift and dump state machine
  stbl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .in_value  (in_value),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_occ   (res_occ)
  );

  // entry storage; a read that hits the entry being written is never used
  stbl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign occ_ext       = {{stbl_pkg::OCC_W{1'b0}}, res_occ};
  assign out_valid     = res_valid;
  assign out_status    = res.status;
  assign out_found     = res.found;
  assign out_entry     = res.entry;
  assign out_occupancy = occ_ext[stbl_pkg::OCC_W-1:0];
  assign out_last      = res.last;

endmodule

// File: hdl/stbl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbl_mem
// entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module stbl_mem #(
  parameter int DEPTH = stbl_pkg::DEFAULT_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [stbl_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [stbl_pkg::DATA_W-1:0] rdata
);

  logic [stbl_pkg::DATA_W-1:0] mem [DEPTH];
  logic [stbl_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/stbl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbl_ctrl
// request sequencer: scans, shifts and dumps the table through the memory
// ----------------------------------------------------------------------------
module stbl_ctrl #(
  parameter int CAPACITY = stbl_pkg::DEFAULT_CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [1:0]                         in_func,
  input  logic signed [stbl_pkg::DATA_W-1:0] in_value,
  output logic                               busy,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output logic [stbl_pkg::DATA_W-1:0]        mem_wdata,
  output logic [AW-1:0]                      mem_raddr,
  input  logic [stbl_pkg::DATA_W-1:0]        mem_rdata,
  output logic                               res_valid,
  output stbl_pkg::result_t                  res,
  output logic [CW-1:0]                      res_occ
);

  stbl_pkg::state_t                   state_r, state_nxt;
  logic [CW-1:0]                      idx_r, idx_nxt;
  logic [CW-1:0]                      count_r, count_nxt;
  logic signed [stbl_pkg::DATA_W-1:0] val_r, val_nxt;
  logic                               del_r, del_nxt;
  logic                               valid_r, valid_nxt;
  stbl_pkg::result_t                  res_r, res_nxt;
  logic [CW-1:0]                      occ_r;
  logic [CW-1:0]                      rd_idx;
  logic signed [stbl_pkg::DATA_W-1:0] rdata_s;

  assign rdata_s = $signed(mem_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbl_pkg::S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    del_r <= del_nxt;
    res_r <= res_nxt;
    occ_r <= count_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    val_nxt   = val_r;
    del_nxt   = del_r;
    valid_nxt = 1'b0;
    res_nxt   = '{status: stbl_pkg::ST_OK, found: 1'b0, entry: val_r, last: 1'b1};
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = val_r;
    rd_idx    = idx_r;

    case (state_r)
      stbl_pkg::S_IDLE: begin
        if (start) begin
          val_nxt = in_value;
          del_nxt = (in_func == stbl_pkg::FUNC_DELETE);
          res_nxt.entry = in_value;
          case (in_func)
            stbl_pkg::FUNC_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                valid_nxt      = 1'b1;
                res_nxt.status = stbl_pkg::ST_FULL;
              end else begin
                // walk down from the top, shifting entries that are equal or larger up
                state_nxt = stbl_pkg::S_INS;
                idx_nxt   = count_r;
                rd_idx    = count_r - CW'(1);
              end
            end
            stbl_pkg::FUNC_DELETE, stbl_pkg::FUNC_SEARCH: begin
              if (count_r == '0) begin
                valid_nxt      = 1'b1;
                res_nxt.status = stbl_pkg::ST_EMPTY;
              end else begin
                state_nxt = stbl_pkg::S_FIND;
                idx_nxt   = '0;
                rd_idx    = '0;
              end
            end
            default: begin
              if (count_r == '0) begin
                valid_nxt      = 1'b1;
                res_nxt.status = stbl_pkg::ST_EMPTY;
                res_nxt.entry  = '0;
              end else begin
                state_nxt = stbl_pkg::S_DUMP;
                idx_nxt   = '0;
                rd_idx    = '0;
              end
            end
          endcase
        end
      end

      stbl_pkg::S_INS: begin
        mem_we = 1'b1;
        if (idx_r != '0 && rdata_s >= val_r) begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_r - CW'(1);
          rd_idx    = idx_r - CW'(2);
        end else begin
          count_nxt = count_r + CW'(1);
          valid_nxt = 1'b1;
          state_nxt = stbl_pkg::S_IDLE;
        end
      end

      stbl_pkg::S_FIND: begin
        if (rdata_s == val_r) begin
          if (del_r) begin
            state_nxt = stbl_pkg::S_DEL;
            rd_idx    = idx_r + CW'(1);
          end else begin
            valid_nxt     = 1'b1;
            res_nxt.found = 1'b1;
            state_nxt     = stbl_pkg::S_IDLE;
          end
        end else if (idx_r + CW'(1) == count_r) begin
          valid_nxt      = 1'b1;
          res_nxt.status = stbl_pkg::ST_NOTFOUND;
          state_nxt      = stbl_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_idx  = idx_r + CW'(1);
        end
      end

      stbl_pkg::S_DEL: begin
        // read data holds the entry just above the write slot
        if (idx_r + CW'(1) < count_r) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          idx_nxt   = idx_r + CW'(1);
          rd_idx    = idx_r + CW'(2);
        end else begin
          count_nxt     = count_r - CW'(1);
          valid_nxt     = 1'b1;
          res_nxt.found = 1'b1;
          state_nxt     = stbl_pkg::S_IDLE;
        end
      end

      stbl_pkg::S_DUMP: begin
        valid_nxt     = 1'b1;
        res_nxt.entry = rdata_s;
        res_nxt.last  = (idx_r + CW'(1) == count_r);
        if (idx_r + CW'(1) == count_r) begin
          state_nxt = stbl_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_idx  = idx_r + CW'(1);
        end
      end

      default: begin
        state_nxt = stbl_pkg::S_IDLE;
      end
    endcase
  end

  assign mem_raddr = rd_idx[AW-1:0];
  assign busy      = (state_r != stbl_pkg::S_IDLE);
  assign res_valid = valid_r;
  assign res       = res_r;
  assign res_occ   = occ_r;

endmodule

// File: hdl/stbl_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbl_chk
// port-level checks of the sorted table engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stbl_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [1:0]                         in_func,
  input logic signed [stbl_pkg::DATA_W-1:0] in_value,
  input logic                               out_valid,
  input logic [1:0]                         out_status,
  input logic                               out_found,
  input logic signed [stbl_pkg::DATA_W-1:0] out_entry,
  input logic [stbl_pkg::OCC_W-1:0]         out_occupancy,
  input logic                               out_last
);

  logic accept;
  assign accept = start && !busy;

  // an accepted request either keeps the engine busy or answers at once
  `ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || out_valid, "request lost")

  // a dump streams without gaps until its last result
  `ASSERT_NEXT(a_dump_no_gap, clk, rst_n, out_valid && !out_last, out_valid, "gap in dump")

  // a match always reports ok
  `ASSERT_SAME(a_found_ok, clk, rst_n, out_valid && out_found, out_status == stbl_pkg::ST_OK, "found without ok")

  // an empty table reports zero occupancy on a single final result
  `ASSERT_SAME(a_empty_occ, clk, rst_n, out_valid && out_status == stbl_pkg::ST_EMPTY, out_occupancy == '0 && out_last, "empty with entries")

endmodule

bind sorted_table_engine stbl_chk u_stbl_chk (.*);

// File: sim/sorted_table_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_engine_test
// self-checking bench for the sorted table engine
// ----------------------------------------------------------------------------
// Requests are sent in bursts with random gaps. A shadow copy of the table
// predicts every result, and each strobed result is compared field by field
// with the oldest prediction. A short directed table comes first. It covers
// the empty table, the value extremes, duplicates, a full table and full-size
// dumps. Rows whose outcome is obvious carry a typed-in result. Random
// requests follow. They swing between filling and draining the table, so
// both the full and the empty corners come up again and again.
// ----------------------------------------------------------------------------
module sorted_table_engine_test;

  localparam int CAPACITY    = stbl_pkg::DEFAULT_CAPACITY;
  localparam int DATA_W      = stbl_pkg::DATA_W;
  localparam int OCC_W       = stbl_pkg::OCC_W;
  localparam int N_DIRECTED  = 25;
  localparam int N_RANDOM    = 375;
  localparam int DRAIN_WAIT  = 64;      // well above the slowest delete
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // one result as it should appear on the out_ ports
  typedef struct packed {
    stbl_pkg::status_t         status;
    logic                      found;
    logic signed [DATA_W-1:0]  entry;
    logic [OCC_W-1:0]          occupancy;
    logic                      last;
  } table_result_t;

  // one row of the directed table; reps > 1 repeats the row with value - k
  typedef struct packed {
    logic [1:0]                func;
    logic signed [DATA_W-1:0]  value;
    logic [4:0]                reps;
    logic                      pinned;
    table_result_t             res;
  } directed_row_t;

  localparam table_result_t NO_PIN = '{stbl_pkg::ST_OK, 1'b0, 32'sd0, 5'd0, 1'b0};

  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    // empty table: every lookup and the dump report empty
    '{stbl_pkg::FUNC_SEARCH, 32'sd5,   5'd1, 1'b1,
      '{stbl_pkg::ST_EMPTY, 1'b0, 32'sd5, 5'd0, 1'b1}},
    '{stbl_pkg::FUNC_DELETE, VAL_MIN,  5'd1, 1'b1,
      '{stbl_pkg::ST_EMPTY, 1'b0, VAL_MIN, 5'd0, 1'b1}},
    '{stbl_pkg::FUNC_DUMP,   32'sd123, 5'd1, 1'b1,
      '{stbl_pkg::ST_EMPTY, 1'b0, 32'sd0, 5'd0, 1'b1}},
    // both extremes, then hit and miss
    '{stbl_pkg::FUNC_INSERT, VAL_MAX,  5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b0, VAL_MAX, 5'd1, 1'b1}},
    '{stbl_pkg::FUNC_INSERT, VAL_MIN,  5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b0, VAL_MIN, 5'd2, 1'b1}},
    '{stbl_pkg::FUNC_SEARCH, VAL_MAX,  5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b1, VAL_MAX, 5'd2, 1'b1}},
    '{stbl_pkg::FUNC_SEARCH, 32'sd0,   5'd1, 1'b1,
      '{stbl_pkg::ST_NOTFOUND, 1'b0, 32'sd0, 5'd2, 1'b1}},
    // duplicates are kept and removed one at a time
    '{stbl_pkg::FUNC_INSERT, 32'sd0,   5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b0, 32'sd0, 5'd3, 1'b1}},
    '{stbl_pkg::FUNC_INSERT, 32'sd0,   5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b0, 32'sd0, 5'd4, 1'b1}},
    '{stbl_pkg::FUNC_INSERT, -32'sd1,  5'd1, 1'b0, NO_PIN},
    '{stbl_pkg::FUNC_INSERT, 32'sd1,   5'd1, 1'b0, NO_PIN},
    '{stbl_pkg::FUNC_DUMP,   32'sd0,   5'd1, 1'b0, NO_PIN},
    '{stbl_pkg::FUNC_DELETE, 32'sd0,   5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b1, 32'sd0, 5'd5, 1'b1}},
    '{stbl_pkg::FUNC_DELETE, 32'sd0,   5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b1, 32'sd0, 5'd4, 1'b1}},
    '{stbl_pkg::FUNC_DELETE, 32'sd0,   5'd1, 1'b1,
      '{stbl_pkg::ST_NOTFOUND, 1'b0, 32'sd0, 5'd4, 1'b1}},
    // fill to capacity with descending values, each lands below the one before it
    '{stbl_pkg::FUNC_INSERT, 32'sd1000, 5'd12, 1'b0, NO_PIN},
    '{stbl_pkg::FUNC_INSERT, 32'sd7,   5'd1, 1'b1,
      '{stbl_pkg::ST_FULL, 1'b0, 32'sd7, 5'd16, 1'b1}},
    '{stbl_pkg::FUNC_DUMP,   32'sd0,   5'd1, 1'b0, NO_PIN},
    '{stbl_pkg::FUNC_DELETE, VAL_MIN,  5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b1, VAL_MIN, 5'd15, 1'b1}},
    '{stbl_pkg::FUNC_SEARCH, VAL_MIN,  5'd1, 1'b1,
      '{stbl_pkg::ST_NOTFOUND, 1'b0, VAL_MIN, 5'd15, 1'b1}},
    '{stbl_pkg::FUNC_INSERT, VAL_MIN + 32'sd1, 5'd1, 1'b0, NO_PIN},
    '{stbl_pkg::FUNC_DELETE, VAL_MAX,  5'd1, 1'b1,
      '{stbl_pkg::ST_OK, 1'b1, VAL_MAX, 5'd15, 1'b1}},
    '{stbl_pkg::FUNC_DELETE, 32'sd995, 5'd1, 1'b0, NO_PIN},
    '{stbl_pkg::FUNC_SEARCH, -32'sd1,  5'd1, 1'b0, NO_PIN},
    '{stbl_pkg::FUNC_DUMP,   32'sd0,   5'd1, 1'b0, NO_PIN}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_func = stbl_pkg::FUNC_INSERT;
  logic signed [DATA_W-1:0]  in_value = '0;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic                      out_found;
  logic signed [DATA_W-1:0]  out_entry;
  logic [OCC_W-1:0]          out_occupancy;
  logic                      out_last;

  // typed-in result that travels with the request it belongs to
  logic                      pin_valid = 1'b0;
  table_result_t             pin_res = NO_PIN;

  // shadow of the table contents and the results still to come
  logic signed [DATA_W-1:0]  shadow_tbl [CAPACITY];
  int                        shadow_count = 0;
  table_result_t             pending_results [$];

  int                        errors = 0;
  int                        cycle_count = 0;
  int                        burst_left = 0;
  bit                        filling = 1'b1;

  sorted_table_engine #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_entry    (out_entry),
    .out_occupancy(out_occupancy),
    .out_last     (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // apply one accepted request to the shadow table and queue its results
  function automatic void apply_request(input logic [1:0] func,
                                        input logic signed [DATA_W-1:0] value);
    table_result_t r;
    int            pos;
    int            i;
    r.status = stbl_pkg::ST_OK;
    r.found  = 1'b0;
    r.entry  = value;
    r.last   = 1'b1;
    case (func)
      stbl_pkg::FUNC_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = stbl_pkg::ST_FULL;
        end else begin
          // in front of the first entry that is equal or greater
          pos = 0;
          while (pos < shadow_count && shadow_tbl[pos] < value) pos++;
          for (i = shadow_count; i > pos; i--) shadow_tbl[i] = shadow_tbl[i-1];
          shadow_tbl[pos] = value;
          shadow_count++;
        end
      end
      stbl_pkg::FUNC_DELETE, stbl_pkg::FUNC_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = stbl_pkg::ST_EMPTY;
        end else begin
          // lowest matching index wins
          pos = shadow_count;
          for (i = shadow_count - 1; i >= 0; i--)
            if (shadow_tbl[i] == value) pos = i;
          if (pos == shadow_count) begin
            r.status = stbl_pkg::ST_NOTFOUND;
          end else begin
            r.found = 1'b1;
            if (func == stbl_pkg::FUNC_DELETE) begin
              for (i = pos; i + 1 < shadow_count; i++) shadow_tbl[i] = shadow_tbl[i+1];
              shadow_count--;
            end
          end
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = stbl_pkg::ST_EMPTY;
          r.entry  = '0;
        end else begin
          // one result per held entry, only the final one marked
          for (i = 0; i < shadow_count; i++) begin
            r.entry     = shadow_tbl[i];
            r.occupancy = OCC_W'(shadow_count);
            r.last      = (i + 1 == shadow_count);
            pending_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.occupancy = OCC_W'(shadow_count);
    pending_results.push_back(r);
  endfunction

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // results are checked before the request taken on the same edge is predicted
  always @(posedge clk) begin : result_monitor
    table_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual entry %0h status %0d",
                   $time, out_entry, out_status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", DATA_W'(want.status), DATA_W'(out_status));
          compare_field("found", DATA_W'(want.found), DATA_W'(out_found));
          compare_field("entry", want.entry, out_entry);
          compare_field("occupancy", DATA_W'(want.occupancy), DATA_W'(out_occupancy));
          compare_field("last", DATA_W'(want.last), DATA_W'(out_last));
        end
      end
      if (start && busy === 1'b0) begin
        apply_request(in_func, in_value);
        // a typed-in row always causes exactly one result
        if (pin_valid) pending_results[pending_results.size() - 1] = pin_res;
      end
    end
  end

  // present a request and hold it until the block takes it
  task automatic issue_request(input logic [1:0] func,
                               input logic signed [DATA_W-1:0] value,
                               input logic pinned, input table_result_t res);
    start     <= 1'b1;
    in_func   <= func;
    in_value  <= value;
    pin_valid <= pinned;
    pin_res   <= res;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // bursts of back-to-back requests, then a random gap with start low
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: gap = 0;
        6:                gap = $urandom_range(20, 40);
        default:          gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 11);
    end
  endtask

  // mostly small values so lookups hit, some held entries, extremes and noise
  function automatic logic signed [DATA_W-1:0] pick_value(input int held_pct);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (shadow_count > 0 && sel < held_pct)
      return shadow_tbl[$urandom_range(shadow_count - 1, 0)];
    sel = $urandom_range(0, 99);
    if (sel < 50) return int'($urandom_range(16, 0)) - 8;
    if (sel < 65) begin
      case ($urandom_range(0, 5))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_MIN + 32'sd1;
        3:       return VAL_MAX - 32'sd1;
        4:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int          r;
    int          k;
    int          n;
    int unsigned pick;
    logic [1:0]  func;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < N_DIRECTED; r++) begin
      for (k = 0; k < DIRECTED[r].reps; k++) begin
        issue_request(DIRECTED[r].func, DIRECTED[r].value - k,
                      DIRECTED[r].pinned, DIRECTED[r].res);
        pace_sender();
      end
    end

    // swing between filling and draining so full and empty recur
    for (n = 0; n < N_RANDOM; n++) begin
      if (shadow_count >= CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (shadow_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      else if ($urandom_range(0, 39) == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (filling)
        func = (pick < 55) ? stbl_pkg::FUNC_INSERT : (pick < 70) ? stbl_pkg::FUNC_DELETE :
               (pick < 90) ? stbl_pkg::FUNC_SEARCH : stbl_pkg::FUNC_DUMP;
      else
        func = (pick < 15) ? stbl_pkg::FUNC_INSERT : (pick < 65) ? stbl_pkg::FUNC_DELETE :
               (pick < 90) ? stbl_pkg::FUNC_SEARCH : stbl_pkg::FUNC_DUMP;
      issue_request(func, pick_value((func == stbl_pkg::FUNC_INSERT) ? 25 : 60),
                    1'b0, NO_PIN);
      pace_sender();
    end
    start <= 1'b0;

    // let every predicted result arrive, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
